// ----- rtl/core/lssc_pkg.sv -----
// Shared types and constants of the LED step sequencer with cross-fade.
// Used by the top level.
`default_nettype none

package lssc_pkg;

  localparam int unsigned PATTERN_W = 16;
  localparam int unsigned TICKS_W   = 16;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned INDEX_W   = 4;
  localparam int unsigned SEQ_LEN_W = 5;
  localparam int unsigned DUTY_W    = 8;

  // Largest table that entry_index can ever address.
  localparam int unsigned INDEX_SPAN = 1 << INDEX_W;

  localparam logic [SEQ_LEN_W-1:0] SEQ_LEN_RESET = 5'd15;
  localparam logic [DUTY_W-1:0]    DUTY_CEIL     = 8'd255;
  localparam logic [DUTY_W-1:0]    DUTY_FLOOR    = 8'd1;
  localparam int unsigned          DUTY_SCALE    = 8;

  // Register index on the configuration port (paddr bit 2).
  localparam logic REG_SEQ_LEN = 1'b0;

  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_LOAD = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [INDEX_W-1:0]   entry_index;
    logic [PATTERN_W-1:0] entry_pattern;
    logic [TICKS_W-1:0]   entry_ticks;
    logic [SHIFT_W-1:0]   entry_shift;
  } req_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] led_pattern;
    logic [DUTY_W-1:0]    timer_preload;
    logic                 preload_valid;
  } res_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern;
    logic [TICKS_W-1:0]   ticks;
    logic [SHIFT_W-1:0]   shift;
  } step_entry_t;

  typedef struct packed {
    logic               en;
    logic [INDEX_W-1:0] addr;
    step_entry_t        entry;
  } tbl_wr_t;

endpackage

`default_nettype wire

// ----- rtl/core/lssc_stream_if.sv -----
// Valid/ready channel carrying one payload beat.
// The payload type is set per instance; no package dependency.
`default_nettype none

interface lssc_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/lssc_step_table.sv -----
// Generic RAM with one write port and one registered read port; a write to the
// address being read shows on the read data at the same edge. No package dependency.
`default_nettype none

module lssc_step_table #(
  parameter int unsigned WIDTH = 36,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Entries have no reset.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && waddr_i == raddr_i) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/core/led_step_sequencer_crossfade_core.sv -----
// Top level of the LED step sequencer with cross-fade: handshakes, config
// register, phase machine and result register. Uses lssc_pkg, lssc_stream_if
// and lssc_step_table.
//
//   channel   dir  protocol       beat contents
//   req_i     in   valid/ready    req_type, entry_index, entry_pattern, ticks, shift
//   res_o     out  valid/ready    led_pattern, timer_preload, preload_valid
//   apb       in   APB, pready=1  sequence_length at byte address 0
//
// Each beat is accepted, evaluated against the state and written to the result
// register at the same edge; one request per clock unless the request side stalls.
// The request side stalls only while a result waits and res_o.ready is low.
// Reset clears the phase machine, the counters and the result valid; the table
// is not cleared; the user must load entries before they are read (not enforced).
`default_nettype none

module led_step_sequencer_crossfade_core #(
  parameter int unsigned MAX_STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  lssc_stream_if.sink               req_i,
  lssc_stream_if.source             res_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready
);
  import lssc_pkg::*;

  localparam int unsigned IDX_W     = $clog2(MAX_STEPS);
  localparam int unsigned TBL_DEPTH = (MAX_STEPS < INDEX_SPAN) ? MAX_STEPS : INDEX_SPAN;
  localparam int unsigned TBL_AW    = $clog2(TBL_DEPTH);
  localparam int unsigned NXT_W     = (IDX_W + 1 > SEQ_LEN_W) ? IDX_W + 1 : SEQ_LEN_W;
  localparam int unsigned DWIDE_W   = TICKS_W - 1 + DUTY_SCALE;

  localparam logic [NXT_W-1:0] MAX_STEPS_N = NXT_W'(MAX_STEPS);
  localparam logic [NXT_W-1:0] TBL_DEPTH_N = NXT_W'(TBL_DEPTH);

  typedef enum logic [1:0] {
    PH_SHOW     = 2'd0,
    PH_FADE_NEW = 2'd1,
    PH_FADE_OLD = 2'd2
  } phase_e;

  // Step wrap: zero once the successor reaches the length or MAX_STEPS.
  function automatic logic [NXT_W-1:0] step_after(input logic [IDX_W-1:0]     step,
                                                  input logic [SEQ_LEN_W-1:0] len);
    logic [NXT_W-1:0] succ;
    succ = NXT_W'(step) + NXT_W'(1);
    if (succ >= NXT_W'(len) || succ >= MAX_STEPS_N) begin
      succ = '0;
    end
    return succ;
  endfunction

  // Configuration port.
  logic [SEQ_LEN_W-1:0] seq_len_q;
  logic                 cfg_wr;
  logic                 seq_len_wr;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign seq_len_wr = cfg_wr && paddr[2] == REG_SEQ_LEN;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_len_q <= SEQ_LEN_RESET;
    end else if (seq_len_wr) begin
      seq_len_q <= pwdata[SEQ_LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_SEQ_LEN) begin
      prdata = {{(32 - SEQ_LEN_W){1'b0}}, seq_len_q};
    end
  end

  // Sequencer state. The cur/prev entry fields are local copies of the table
  // so that the table only needs a read port at the next step. The table is
  // read ahead, at the successor of the step that each edge leaves current, so
  // its registered data always holds the next step's entry.
  phase_e               phase_q, phase_d;
  logic [TICKS_W-1:0]   elapsed_q, elapsed_d;
  logic [DUTY_W-1:0]    duty_q, duty_d;
  logic [IDX_W-1:0]     cur_q, cur_d;
  logic [IDX_W-1:0]     prev_q, prev_d;
  logic [SHIFT_W-1:0]   fade_shift_q, fade_shift_d;
  logic [TICKS_W-1:0]   hold_q, hold_d;
  logic [PATTERN_W-1:0] drv_q, drv_d;
  logic [PATTERN_W-1:0] cur_pat_q, cur_pat_d, prev_pat_q, prev_pat_d;
  logic [SHIFT_W-1:0]   cur_shift_q, cur_shift_d, prev_shift_q, prev_shift_d;

  logic                 res_valid_q;
  res_t                 res_q, res_d;

  req_t                 req;
  logic                 accept;
  logic                 is_load;
  logic                 load_ok;
  logic [NXT_W-1:0]     next_full;
  logic [IDX_W-1:0]     next_idx;
  logic                 next_in_tbl;
  logic [IDX_W-1:0]     cur_nx;
  logic [SEQ_LEN_W-1:0] seq_len_nx;
  logic [NXT_W-1:0]     rd_full;
  step_entry_t          tbl_rd;
  step_entry_t          next_entry;
  tbl_wr_t              tbl_wr;
  logic [TICKS_W-1:0]   elapsed_inc;
  logic [TICKS_W-2:0]   half;
  logic [DWIDE_W-1:0]   duty_wide;
  logic [DUTY_W-1:0]    duty_clamped;
  logic                 fade_done;

  assign req     = req_i.payload;
  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept  = req_i.valid && req_i.ready;
  assign is_load = (req.req_type == REQ_LOAD);
  assign load_ok = is_load && (NXT_W'(req.entry_index) < MAX_STEPS_N);

  assign tbl_wr.en    = accept && load_ok;
  assign tbl_wr.addr  = req.entry_index;
  assign tbl_wr.entry = '{pattern: req.entry_pattern, ticks: req.entry_ticks,
                          shift: req.entry_shift};

  assign next_full   = step_after(cur_q, seq_len_q);
  assign next_idx    = next_full[IDX_W-1:0];
  assign next_in_tbl = next_full < TBL_DEPTH_N;

  assign cur_nx     = accept ? cur_d : cur_q;
  assign seq_len_nx = seq_len_wr ? pwdata[SEQ_LEN_W-1:0] : seq_len_q;
  assign rd_full    = step_after(cur_nx, seq_len_nx);

  lssc_step_table #(
    .WIDTH ($bits(step_entry_t)),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_wr.en),
    .waddr_i (tbl_wr.addr[TBL_AW-1:0]),
    .wdata_i (tbl_wr.entry),
    .raddr_i (rd_full[TBL_AW-1:0]),
    .rdata_o (tbl_rd)
  );

  assign next_entry = next_in_tbl ? tbl_rd : '0;

  assign elapsed_inc = elapsed_q + TICKS_W'(1);
  assign half        = elapsed_inc[TICKS_W-1:1];
  assign fade_done   = (half >> fade_shift_q) != '0;
  assign duty_wide   = {half, {DUTY_SCALE{1'b0}}} >> prev_shift_q;

  always_comb begin
    if (duty_wide > DWIDE_W'(DUTY_CEIL)) begin
      duty_clamped = DUTY_CEIL;
    end else if (duty_wide == '0) begin
      duty_clamped = DUTY_FLOOR;
    end else begin
      duty_clamped = duty_wide[DUTY_W-1:0];
    end
  end

  always_comb begin
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    duty_d       = duty_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    fade_shift_d = fade_shift_q;
    hold_d       = hold_q;
    drv_d        = drv_q;
    cur_pat_d    = cur_pat_q;
    cur_shift_d  = cur_shift_q;
    prev_pat_d   = prev_pat_q;
    prev_shift_d = prev_shift_q;
    res_d        = '0;

    if (is_load) begin
      // Keep the copies coherent with the table.
      if (load_ok && NXT_W'(req.entry_index) == NXT_W'(cur_q)) begin
        cur_pat_d   = req.entry_pattern;
        cur_shift_d = req.entry_shift;
      end
      if (load_ok && NXT_W'(req.entry_index) == NXT_W'(prev_q)) begin
        prev_pat_d   = req.entry_pattern;
        prev_shift_d = req.entry_shift;
      end
    end else begin
      elapsed_d = elapsed_inc;
      case (phase_q)
        PH_FADE_NEW: begin
          drv_d = cur_pat_q;
          if (fade_done) begin
            elapsed_d = '0;
            phase_d   = PH_SHOW;
          end else begin
            duty_d              = duty_clamped;
            res_d.timer_preload = DUTY_W'(0) - duty_clamped;
            res_d.preload_valid = 1'b1;
            phase_d             = PH_FADE_OLD;
          end
        end
        PH_FADE_OLD: begin
          drv_d               = prev_pat_q;
          res_d.timer_preload = duty_q;
          res_d.preload_valid = 1'b1;
          phase_d             = PH_FADE_NEW;
        end
        default: begin
          phase_d = PH_SHOW;
          if (elapsed_inc >= hold_q) begin
            prev_d       = cur_q;
            prev_pat_d   = cur_pat_q;
            prev_shift_d = cur_shift_q;
            fade_shift_d = cur_shift_q;
            cur_d        = next_idx;
            cur_pat_d    = next_entry.pattern;
            cur_shift_d  = next_entry.shift;
            elapsed_d    = '0;
            hold_d       = next_entry.ticks - (TICKS_W'(1) << next_entry.shift);
            phase_d      = PH_FADE_NEW;
          end
        end
      endcase
    end
    res_d.led_pattern = drv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_SHOW;
      elapsed_q    <= '0;
      duty_q       <= '0;
      cur_q        <= '0;
      prev_q       <= '0;
      fade_shift_q <= '0;
      hold_q       <= '0;
      drv_q        <= '0;
      res_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        phase_q      <= phase_d;
        elapsed_q    <= elapsed_d;
        duty_q       <= duty_d;
        cur_q        <= cur_d;
        prev_q       <= prev_d;
        fade_shift_q <= fade_shift_d;
        hold_q       <= hold_d;
        drv_q        <= drv_d;
        res_valid_q  <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cur_pat_q    <= cur_pat_d;
      cur_shift_q  <= cur_shift_d;
      prev_pat_q   <= prev_pat_d;
      prev_shift_q <= prev_shift_d;
      res_q        <= res_d;
    end
  end

  assign res_o.valid   = res_valid_q;
  assign res_o.payload = res_q;

  // The step pointers stay below MAX_STEPS.
  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    NXT_W'(cur_q) < MAX_STEPS_N && NXT_W'(prev_q) < MAX_STEPS_N)
    else $error("step pointer beyond MAX_STEPS");

  // A load beat leaves the phase machine and the counters alone.
  a_load_no_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_load) |=> ($stable(phase_q) && $stable(cur_q) && $stable(elapsed_q)))
    else $error("load beat changed sequencer state");

  // A fade-new tick that reloads the timer hands over to the old pattern.
  a_fade_alternates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_load && phase_q == PH_FADE_NEW && !fade_done)
    |=> (phase_q == PH_FADE_OLD && res_q.preload_valid))
    else $error("fade did not alternate");

  // Without a reload the preload field reads zero.
  a_preload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && !res_q.preload_valid) |-> (res_q.timer_preload == '0))
    else $error("preload nonzero without reload");

  // An empty result register never stalls the request side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_valid_q |-> req_i.ready)
    else $error("request stalled with empty result register");

endmodule

`default_nettype wire
